### hdl/majority_ack_broadcast_tracker_unit_defines.svh
// Assertion macros used by the majority acknowledgement tracker datapath.
// Included by mabt_dp, the file that carries concurrent assertions; no other dependencies.
`ifndef MAJORITY_ACK_BROADCAST_TRACKER_UNIT_DEFINES_SVH
`define MAJORITY_ACK_BROADCAST_TRACKER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MABT_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mabt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MABT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mabt assertion failed");

`endif

### hdl/mabt_pkg.sv
// Shared types, codes and constants of the majority acknowledgement tracker.
// Used by the controller, the datapath and the top level; no dependencies.
package mabt_pkg;

   localparam int DEF_MAX_PROCS   = 16;
   localparam int DEF_TABLE_DEPTH = 64;

   localparam int RANK_W      = 5;
   localparam int ID_W        = 64;
   localparam int REQ_DATA_W  = 144;
   localparam int RSP_DATA_W  = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SELF_RANK     = 8'd1;
   localparam logic [RANK_W-1:0]      CFG_RESET_VALUE   = 5'd1;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED   = 2'd0,
      STATUS_BAD_RANK   = 2'd1,
      STATUS_TABLE_FULL = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_UPDATE,
      ST_COUNT,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic set_bad;
      logic scan;
      logic set_full;
      logic update;
      logic count;
      logic finish;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic rank_ok;
      logic hit;
      logic miss;
      logic full;
      logic out_free;
   } stat_type;

endpackage

### hdl/mabt_ctrl.sv
// Sequencer of the tracker: steps one request through check, scan, update, count, finish and respond.
// Depends on mabt_pkg; drives the datapath through command and status structs.
module mabt_ctrl
   import mabt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.rank_ok ? ST_SCAN : ST_RESPOND;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = ST_UPDATE;
            end else if (stat.miss) begin
               state_in = stat.full ? ST_RESPOND : ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_COUNT;
         ST_COUNT:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CHECK:   cmd.set_bad  = !stat.rank_ok;
         ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.set_full = !stat.hit && stat.miss && stat.full;
         end
         ST_UPDATE:  cmd.update   = 1'b1;
         ST_COUNT:   cmd.count    = 1'b1;
         ST_FINISH:  cmd.finish   = 1'b1;
         ST_RESPOND: cmd.out_load = stat.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/mabt_dp.sv
// Datapath of the tracker: configuration registers, message table memory,
// sequential id scan, acknowledgement count and result register.
// Depends on mabt_pkg and the assertion macro header.
`include "majority_ack_broadcast_tracker_unit_defines.svh"

module mabt_dp
   import mabt_pkg::*;
#(
   parameter int MAX_PROCS   = DEF_MAX_PROCS,
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [RANK_W-1:0]      origin_rank,
   input  logic [ID_W-1:0]        msg_id_high,
   input  logic [ID_W-1:0]        msg_id_low,
   input  logic [RANK_W-1:0]      relay_rank,
   input  cmd_type                cmd,
   output stat_type               stat,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output rsp_status_type         rsp_status,
   output logic                   rsp_relay,
   output logic                   rsp_deliver,
   output logic [RANK_W-1:0]      rsp_deliver_origin,
   output logic [RANK_W-1:0]      rsp_ack_count
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int USED_W = $clog2(TABLE_DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int GROUPS = (MAX_PROCS + 7) / 8;
   localparam int PC_CAP = (MAX_PROCS > 31) ? 31 : MAX_PROCS;
   localparam logic [RANK_W-1:0] PC_CAP_V = RANK_W'(PC_CAP);
   localparam logic [USED_W-1:0] DEPTH_V  = USED_W'(TABLE_DEPTH);

   typedef struct packed {
      logic [ID_W-1:0]      id_high;
      logic [ID_W-1:0]      id_low;
      logic [MAX_PROCS-1:0] ack;
      logic                 delivered;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   entry_type wr_entry;

   logic [RANK_W-1:0]    process_count_ff;
   logic [RANK_W-1:0]    self_rank_ff;
   logic [RANK_W-1:0]    pc_eff;
   logic [RANK_W-1:0]    quorum;

   logic [RANK_W-1:0]    origin_ff;
   logic [ID_W-1:0]      id_high_ff;
   logic [ID_W-1:0]      id_low_ff;
   logic [RANK_W-1:0]    relay_ff;

   logic [USED_W-1:0]    used_ff;
   logic [USED_W-1:0]    used_in;
   logic [USED_W-1:0]    rd_idx_ff;
   logic [USED_W-1:0]    rd_idx_in;
   logic                 cmp_valid_ff;
   logic                 cmp_valid_in;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 issue;
   logic                 hit;
   logic                 miss;

   logic [IDX_W-1:0]     slot_ff;
   logic [MAX_PROCS-1:0] ack_ff;
   logic                 deliv_ff;
   logic                 fresh_ff;
   logic [MAX_PROCS-1:0] relay_bit;
   logic [MAX_PROCS-1:0] count_mask;
   logic [GROUPS*8-1:0]  ack_ext;
   logic [3:0]           grp_in [GROUPS];
   logic [3:0]           grp_ff [GROUPS];
   logic [CNT_W-1:0]     total;
   logic [RANK_W-1:0]    acks;
   logic                 deliver_now;

   rsp_status_type       res_status_ff;
   logic                 res_relay_ff;
   logic                 res_deliver_ff;
   logic [RANK_W-1:0]    res_origin_ff;
   logic [RANK_W-1:0]    res_acks_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         process_count_ff <= CFG_RESET_VALUE;
         self_rank_ff     <= CFG_RESET_VALUE;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROCESS_COUNT: process_count_ff <= csr_data[RANK_W-1:0];
            CSR_SELF_RANK:     self_rank_ff     <= csr_data[RANK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign pc_eff = (process_count_ff > PC_CAP_V) ? PC_CAP_V : process_count_ff;
   assign quorum = (pc_eff >> 1) + RANK_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         origin_ff  <= origin_rank;
         id_high_ff <= msg_id_high;
         id_low_ff  <= msg_id_low;
         relay_ff   <= relay_rank;
      end
   end

   assign stat.rank_ok = (origin_ff != '0) && (origin_ff <= pc_eff)
                      && (relay_ff != '0) && (relay_ff <= pc_eff);

   // The table fills from entry zero and never frees, so the fill count
   // marks which entries hold a message.
   assign hit   = cmp_valid_ff && (rd_data_ff.id_high == id_high_ff)
               && (rd_data_ff.id_low == id_low_ff);
   assign issue = cmd.scan && !hit && (rd_idx_ff < used_ff);
   assign miss  = !cmp_valid_ff && (rd_idx_ff == used_ff);

   assign stat.hit      = hit;
   assign stat.miss     = miss;
   assign stat.full     = (used_ff == DEPTH_V);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      if (cmd.load) begin
         rd_idx_in    = '0;
         cmp_valid_in = 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_in = issue;
         if (issue) begin
            rd_idx_in = rd_idx_ff + USED_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_idx_ff[IDX_W-1:0]];
         cmp_idx_ff <= rd_idx_ff[IDX_W-1:0];
      end
      if (cmd.finish) begin
         mem[slot_ff] <= wr_entry;
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PROCS; i++) begin
         relay_bit[i]  = (32'(relay_ff) == 32'(i + 1));
         count_mask[i] = (32'(i) < 32'(pc_eff));
      end
      ack_ext = '0;
      ack_ext[MAX_PROCS-1:0] = ack_ff & count_mask;
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            grp_in[g] = grp_in[g] + 4'(ack_ext[g*8+b]);
         end
      end
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + CNT_W'(grp_ff[g]);
      end
   end

   assign acks        = RANK_W'(total);
   assign deliver_now = !deliv_ff && (acks >= quorum);

   always_comb begin
      wr_entry.id_high   = id_high_ff;
      wr_entry.id_low    = id_low_ff;
      wr_entry.ack       = ack_ff;
      wr_entry.delivered = deliv_ff | deliver_now;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && hit) begin
         slot_ff  <= cmp_idx_ff;
         ack_ff   <= rd_data_ff.ack;
         deliv_ff <= rd_data_ff.delivered;
         fresh_ff <= 1'b0;
      end else if (cmd.scan && miss) begin
         slot_ff  <= used_ff[IDX_W-1:0];
         ack_ff   <= '0;
         deliv_ff <= 1'b0;
         fresh_ff <= 1'b1;
      end else if (cmd.update) begin
         ack_ff <= ack_ff | relay_bit;
      end
      if (cmd.count) begin
         for (int g = 0; g < GROUPS; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.finish && fresh_ff) begin
         used_in = used_ff + USED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_bad || cmd.set_full) begin
         res_status_ff  <= cmd.set_bad ? STATUS_BAD_RANK : STATUS_TABLE_FULL;
         res_relay_ff   <= 1'b0;
         res_deliver_ff <= 1'b0;
         res_origin_ff  <= '0;
         res_acks_ff    <= '0;
      end else if (cmd.finish) begin
         res_status_ff  <= STATUS_ACCEPTED;
         res_relay_ff   <= fresh_ff && (origin_ff != self_rank_ff);
         res_deliver_ff <= deliver_now;
         res_origin_ff  <= deliver_now ? origin_ff : '0;
         res_acks_ff    <= acks;
      end
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status         <= res_status_ff;
         rsp_relay          <= res_relay_ff;
         rsp_deliver        <= res_deliver_ff;
         rsp_deliver_origin <= res_origin_ff;
         rsp_ack_count      <= res_acks_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `MABT_ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1, used_ff <= DEPTH_V)
   `MABT_ASSERT_IMPLIES(a_hit_in_table, clock, reset, hit,
      {1'b0, cmp_idx_ff} < {1'b0, used_ff})
   `MABT_ASSERT_NEXT(a_used_step, clock, reset, 1'b1,
      (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + USED_W'(1)))
   `MABT_ASSERT_IMPLIES(a_reject_clean, clock, reset,
      rsp_valid_ff && (rsp_status != STATUS_ACCEPTED),
      !rsp_relay && !rsp_deliver && (rsp_ack_count == '0))

endmodule

### hdl/majority_ack_broadcast_tracker_unit.sv
// A request is answered after the one-entry-per-cycle id scan of a single-port memory,
// which dominates the time to answer; a bad rank is answered without a scan.
// One request at a time; the next is taken in the cycle after the result is loaded into the
// output register, which waits until the previous result has left.
// Reset: synchronous, active high; clears fill count, control and output valid, sets
// the group size and own rank to one. No clearing pass is needed.
module majority_ack_broadcast_tracker_unit
   import mabt_pkg::*;
#(
   parameter int MAX_PROCS   = DEF_MAX_PROCS,
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // origin_rank[4:0], msg_id_high[68:5], msg_id_low[132:69], relay_rank[137:133]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[1:0], relay[2], deliver[3], deliver_origin[8:4], ack_count[13:9]
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   cmd_type           cmd;
   stat_type          stat;
   rsp_status_type    rsp_status;
   logic              rsp_relay;
   logic              rsp_deliver;
   logic [RANK_W-1:0] rsp_deliver_origin;
   logic [RANK_W-1:0] rsp_ack_count;

   mabt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mabt_dp #(
      .MAX_PROCS   (MAX_PROCS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .origin_rank        (req_tdata[4:0]),
      .msg_id_high        (req_tdata[68:5]),
      .msg_id_low         (req_tdata[132:69]),
      .relay_rank         (req_tdata[137:133]),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_status         (rsp_status),
      .rsp_relay          (rsp_relay),
      .rsp_deliver        (rsp_deliver),
      .rsp_deliver_origin (rsp_deliver_origin),
      .rsp_ack_count      (rsp_ack_count)
   );

   assign rsp_tdata = {2'b00, rsp_ack_count, rsp_deliver_origin, rsp_deliver,
                       rsp_relay, rsp_status};

endmodule
